// ===== hdl/skts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_pkg: shared types and constants
// Types, widths and command codes for the sorted key table search block.
// ---------------------------------------------------------------------------
package skts_pkg;

  localparam int TableDepth = 1024;
  localparam int KeyBytes   = 8;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int KeyW       = 64;
  localparam int QDepth     = 2;

  localparam logic [0:0] CFG_ENTRY_COUNT   = 1'b0;
  localparam logic [0:0] CFG_MAX_KEY_BYTES = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_EXACT  = 2'd1,
    CMD_PREFIX = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  slot;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] rec_offset;
    logic [31:0] rec_size;
    logic [7:0]  file_number;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  match_index;
    logic [31:0] match_offset;
    logic [31:0] match_size;
    logic [7:0]  match_file;
  } out_item_t;

  // classified find job type; the front to back queue carries in_item_t instead
  typedef struct packed {
    logic        prefix;
    logic [3:0]  nbytes;
    logic [63:0] key;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CMP_FIRST,
    ST_CMP_LAST,
    ST_MID,
    ST_CMP_MID,
    ST_BACK,
    ST_CMP_BACK,
    ST_FETCH,
    ST_DONE
  } state_t;

  localparam int RecW = 72;

  // -1/0/+1 encoded as lt, eq
  function automatic logic [1:0] key_cmp(input logic [63:0] q, input logic [63:0] s,
                                         input logic [3:0] nbytes, input logic prefix);
    logic [1:0] res;
    logic       stop;
    logic [7:0] a;
    logic [7:0] b;
    res  = 2'b01;
    stop = 1'b0;
    for (int i = 0; i < KeyBytes; i++) begin
      a = q[63-8*i -: 8];
      b = s[63-8*i -: 8];
      if (!stop && (i < 32'(nbytes))) begin
        if (a != b) begin
          res  = (a < b) ? 2'b10 : 2'b00;
          stop = 1'b1;
        end else if (!prefix && a == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return res;  // bit1 lt, bit0 eq
  endfunction

endpackage

// ===== hdl/skts_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_stream_if: valid/ready channel
// Carries one payload type with a source and a sink view.
// ---------------------------------------------------------------------------
interface skts_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/skts_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_ram: generic single port ram
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module skts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

// ===== hdl/skts_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_front: command classifier
// Takes transactions, turns finds into jobs with their compare length, hands
// loads on as jobs too, and drops unused commands.
// ---------------------------------------------------------------------------
module skts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          max_key_bytes,
  skts_stream_if.sink         in_if,
  output logic                q_push,
  output skts_pkg::in_item_t  q_data,
  input  logic                q_full
);
  import skts_pkg::*;

  logic [3:0] width;
  logic [3:0] klen;
  logic       is_prefix;

  assign in_if.ready = !q_full;
  assign width     = (max_key_bytes > 4'(KeyBytes)) ? 4'(KeyBytes) : max_key_bytes;
  assign is_prefix = (in_if.data.cmd == CMD_PREFIX);
  assign klen      = (in_if.data.key_len > width) ? width : in_if.data.key_len;

  always_comb begin
    q_push = in_if.valid && !q_full && (in_if.data.cmd != CMD_NONE);
    q_data = in_if.data;
    // key_len field reused as compare length for finds
    if (in_if.data.cmd != CMD_LOAD) begin
      q_data.key_len = is_prefix ? klen : width;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("push into full queue");
  a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.data.cmd == CMD_NONE) |-> !q_push)
    else $error("unused command queued");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.cmd != CMD_LOAD) |-> q_data.key_len <= 4'(KeyBytes))
    else $error("compare length too large");
`endif
endmodule

// ===== hdl/skts_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_queue: small job fifo
// Decouples the front classifier from the search engine.
// ---------------------------------------------------------------------------
module skts_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  skts_pkg::in_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output skts_pkg::in_item_t head
);
  import skts_pkg::*;

  localparam int PW = $clog2(QDepth);

  in_item_t      mem_r [QDepth];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDepth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty) else $error("queue lost an entry");
`endif
endmodule

// ===== hdl/skts_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skts_back: search engine
// Writes loads into the table and runs end checks, bisection and prefix
// step-back for finds.
// ---------------------------------------------------------------------------
module skts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [10:0]        entry_count,
  input  logic               q_empty,
  input  skts_pkg::in_item_t q_head,
  output logic               q_pop,
  skts_stream_if.source      out_if
);
  import skts_pkg::*;

  state_t            st_r, st_nxt;
  logic [IdxW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, cur_r, cur_nxt;
  logic              ovalid_r, ovalid_nxt;
  out_item_t         odata_r, odata_nxt;

  logic              we;
  logic [IdxW-1:0]   addr;
  logic [KeyW-1:0]   key_rd;
  logic [RecW-1:0]   rec_rd;
  logic [1:0]        cmp;
  logic [CntW-1:0]   n;
  logic [IdxW:0]     sum;
  logic [IdxW-1:0]   mid;

  skts_ram #(.Width(KeyW), .Depth(TableDepth)) u_key_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(q_head.key), .rdata(key_rd));
  skts_ram #(.Width(RecW), .Depth(TableDepth)) u_rec_ram (
    .clk(clk), .we(we), .addr(addr),
    .wdata({q_head.rec_offset, q_head.rec_size, q_head.file_number}), .rdata(rec_rd));

  assign n   = (entry_count > 11'(TableDepth)) ? CntW'(TableDepth) : CntW'(entry_count);
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[IdxW:1];
  assign cmp = key_cmp(q_head.key, key_rd, q_head.key_len, q_head.cmd == CMD_PREFIX);
  assign out_if.valid = ovalid_r;
  assign out_if.data  = odata_r;

  always_comb begin
    st_nxt     = st_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    cur_nxt    = cur_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    odata_nxt  = odata_r;
    we         = 1'b0;
    addr       = cur_r;
    q_pop      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.cmd == CMD_LOAD) begin
            we    = 1'b1;
            addr  = q_head.slot;
            q_pop = 1'b1;
          end else if (!ovalid_nxt) begin
            lo_nxt  = '0;
            hi_nxt  = IdxW'(n - 1'b1);
            cur_nxt = '0;
            if (n == '0) begin
              odata_nxt  = '0;
              ovalid_nxt = 1'b1;
              q_pop      = 1'b1;
            end else begin
              addr   = '0;
              st_nxt = ST_CMP_FIRST;
            end
          end
        end
      end
      ST_CMP_FIRST: begin
        if (cmp[0]) begin
          st_nxt = ST_BACK;
        end else begin
          cur_nxt = hi_r;
          addr    = hi_r;
          st_nxt  = ST_CMP_LAST;
        end
      end
      ST_CMP_LAST: begin
        if (cmp[0]) begin
          st_nxt = ST_BACK;
        end else begin
          st_nxt = ST_MID;
        end
      end
      ST_MID: begin
        if (mid == lo_r || mid == hi_r) begin
          odata_nxt  = '0;
          ovalid_nxt = 1'b1;
          q_pop      = 1'b1;
          st_nxt     = ST_IDLE;
        end else begin
          cur_nxt = mid;
          addr    = mid;
          st_nxt  = ST_CMP_MID;
        end
      end
      ST_CMP_MID: begin
        if (cmp[0]) begin
          st_nxt = ST_BACK;
        end else begin
          if (cmp[1]) hi_nxt = cur_r;
          else lo_nxt = cur_r;
          st_nxt = ST_MID;
        end
      end
      ST_BACK: begin
        // step back over earlier prefix matches
        if (q_head.cmd == CMD_PREFIX && cur_r != '0) begin
          addr   = cur_r - 1'b1;
          st_nxt = ST_CMP_BACK;
        end else begin
          addr   = cur_r;
          st_nxt = ST_FETCH;
        end
      end
      ST_CMP_BACK: begin
        if (cmp[0]) begin
          cur_nxt = cur_r - 1'b1;
        end
        st_nxt = cmp[0] ? ST_BACK : ST_RD_FIRST;
      end
      ST_RD_FIRST: begin
        addr   = cur_r;
        st_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        odata_nxt.found        = 1'b1;
        odata_nxt.match_index  = 10'(cur_r);
        odata_nxt.match_offset = rec_rd[71:40];
        odata_nxt.match_size   = rec_rd[39:8];
        odata_nxt.match_file   = rec_rd[7:0];
        ovalid_nxt = 1'b1;
        q_pop      = 1'b1;
        st_nxt     = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ovalid_r <= ovalid_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    cur_r   <= cur_nxt;
    odata_r <= odata_nxt;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_if.ready) |=> (ovalid_r && $stable(odata_r)))
    else $error("result dropped while stalled");
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MID) |-> lo_r <= hi_r) else $error("search interval inverted");
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && st_r != ST_IDLE) |=> st_r == ST_IDLE)
    else $error("find finished without return to idle");
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !odata_r.found) |-> odata_r.match_index == '0)
    else $error("miss carries an index");
`endif
endmodule

// ===== hdl/sorted_key_table_search_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_key_table_search_top: sorted key table search
// Holds a key-sorted record table; loads write a slot, finds bisect it.
// ---------------------------------------------------------------------------
// a load writes its slot in the engine; a find tests the first entry, then the
//   last, then bisects until a hit or until the midpoint meets an end of the
//   interval (a miss); a hit first steps back over earlier matching entries on
//   a prefix find, then fetches its record
// throughput: one find at a time, set by the single table read port
// reset: synchronous active low; entry_count 0, max_key_bytes 8, queue empty
module sorted_key_table_search_top
  import skts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  skts_stream_if.sink   in_if,
  skts_stream_if.source out_if
);

  // configuration registers
  logic [10:0] entry_count_r;
  logic [3:0]  max_key_bytes_r;

  // front to back job queue
  logic     q_push, q_full, q_pop, q_empty;
  in_item_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      max_key_bytes_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT:   entry_count_r   <= cfg_wdata;
        CFG_MAX_KEY_BYTES: max_key_bytes_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // classify incoming transactions
  skts_front u_front (
    .clk(clk), .rst_n(rst_n), .max_key_bytes(max_key_bytes_r),
    .in_if(in_if), .q_push(q_push), .q_data(q_in), .q_full(q_full));

  skts_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head));

  // table and search engine
  skts_back u_back (
    .clk(clk), .rst_n(rst_n), .entry_count(entry_count_r),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .out_if(out_if));

`ifndef SYNTHESIS
  a_cfg_reset: assert property (@(posedge clk)
    !rst_n |=> (entry_count_r == '0 && max_key_bytes_r == 4'd8))
    else $error("config not reset");
  a_out_valid_reset: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid) else $error("result after reset");
  a_in_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_if.ready) else $error("ready while queue full");
`endif
endmodule
